// ===== hw/rtl/srow_pkg.sv =====
// Shared types and constants of the sketch row counter block.
`default_nettype none

package srow_pkg;

   localparam int unsigned HASH_W = 32;
   localparam int unsigned AMT_W  = 31;
   localparam int unsigned VAL_W  = 8;
   localparam int unsigned BIN_W  = 8;
   localparam int unsigned BINS   = 256;
   localparam int unsigned BCNT_W = 18;
   localparam int unsigned NZ_W   = 17;
   localparam int unsigned CSR_W  = 17;
   localparam int unsigned CMD_W  = 3;

   localparam logic [VAL_W-1:0] SAT_MAX   = 8'd255;
   localparam logic [CSR_W-1:0] CSR_RESET = 17'h10000;

   // Remainder unit: quotient bits retired per cycle
   localparam int unsigned MOD_BITS   = 4;
   localparam int unsigned MOD_STEPS  = HASH_W / MOD_BITS;
   localparam int unsigned MOD_STEP_W = $clog2(MOD_STEPS);

   localparam int unsigned QDEPTH = 2;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);

   localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_MAX   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
   localparam logic [CMD_W-1:0] CMD_BIN   = 3'd4;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_MAX,
      OP_QUERY,
      OP_CLEAR,
      OP_BIN,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [HASH_W-1:0]  key_hash;
      logic [VAL_W-1:0]   amount;
      logic [BIN_W-1:0]   bin_index;
   } item_type;

endpackage

`default_nettype wire

// ===== hw/rtl/srow_if.sv =====
// Request and response channel interfaces of the sketch row counter block.
`default_nettype none

interface srow_req_if;
   logic                                valid;
   logic                                ready;
   logic [srow_pkg::CMD_W-1:0]          cmd;
   logic [srow_pkg::HASH_W-1:0]         key_hash;
   logic [srow_pkg::AMT_W-1:0]          amount;
   logic [srow_pkg::BIN_W-1:0]          bin_index;

   modport source (output valid, cmd, key_hash, amount, bin_index, input ready);
   modport sink   (input valid, cmd, key_hash, amount, bin_index, output ready);
endinterface

interface srow_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [srow_pkg::VAL_W-1:0]          counter_value;
   logic signed [srow_pkg::BCNT_W-1:0]  bin_count;
   logic [srow_pkg::NZ_W-1:0]           nonzero_count;

   modport source (output valid, counter_value, bin_count, nonzero_count, input ready);
   modport sink   (input valid, counter_value, bin_count, nonzero_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/srow_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srow_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/srow_front.sv =====
// Front end: accepts request transactions, saturates the amount and decodes the command.
`default_nettype none

module srow_front (
   srow_req_if.sink                 req_if,
   input  wire logic                queue_full,
   input  wire logic                sweep_busy,
   output      logic                push,
   output      srow_pkg::item_type  push_item
);

   srow_pkg::op_type op;

   always_comb begin
      unique case (req_if.cmd)
         srow_pkg::CMD_ADD:   op = srow_pkg::OP_ADD;
         srow_pkg::CMD_MAX:   op = srow_pkg::OP_MAX;
         srow_pkg::CMD_QUERY: op = srow_pkg::OP_QUERY;
         srow_pkg::CMD_CLEAR: op = srow_pkg::OP_CLEAR;
         srow_pkg::CMD_BIN:   op = srow_pkg::OP_BIN;
         default:             op = srow_pkg::OP_NONE;
      endcase
   end

   assign req_if.ready = !queue_full && !sweep_busy;
   assign push         = req_if.valid && req_if.ready;

   always_comb begin
      push_item.op        = op;
      push_item.key_hash  = req_if.key_hash;
      push_item.bin_index = req_if.bin_index;
      // clamp to the counter range
      if (req_if.amount > srow_pkg::AMT_W'(srow_pkg::SAT_MAX)) begin
         push_item.amount = srow_pkg::SAT_MAX;
      end else begin
         push_item.amount = req_if.amount[srow_pkg::VAL_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/srow_fifo.sv =====
// Short queue of decoded transactions between the front and back ends.
`default_nettype none

module srow_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire srow_pkg::item_type  push_item,
   input  wire logic                pop,
   output      srow_pkg::item_type  head_item,
   output      logic                empty,
   output      logic                full
);

   srow_pkg::item_type                slot_ff [srow_pkg::QDEPTH];
   logic [srow_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [srow_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [srow_pkg::QPTR_W:0]         count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == (srow_pkg::QPTR_W+1)'(srow_pkg::QDEPTH));
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/srow_mod.sv =====
// Iterative remainder unit: hash modulo counter count, several bits per cycle.
`default_nettype none

module srow_mod #(
   parameter int unsigned MOD_W = 17
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [srow_pkg::HASH_W-1:0] dividend,
   input  wire logic [MOD_W-1:0]            divisor,
   output      logic                        done,
   output      logic [MOD_W-1:0]            remainder
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [srow_pkg::MOD_STEP_W-1:0]   step_ff, step_in;
   logic [srow_pkg::HASH_W-1:0]       dvd_ff, dvd_in;
   logic [MOD_W-1:0]                  div_ff, div_in;
   logic [MOD_W-1:0]                  rem_ff, rem_in;
   logic [MOD_W-1:0]                  rem_step;

   // Restoring steps: remainder stays below the divisor, so one subtract per bit
   always_comb begin
      logic [MOD_W:0] r;
      r = {1'b0, rem_ff};
      for (int i = 0; i < srow_pkg::MOD_BITS; i++) begin
         r = {r[MOD_W-1:0], dvd_ff[srow_pkg::HASH_W-1-i]};
         if (r >= {1'b0, div_ff}) begin
            r = r - {1'b0, div_ff};
         end
      end
      rem_step = r[MOD_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = rem_step;
         dvd_in  = dvd_ff << srow_pkg::MOD_BITS;
         step_in = step_ff + 1'b1;
         if (step_ff == srow_pkg::MOD_STEP_W'(srow_pkg::MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/srow_back.sv =====
// Back end: counter and histogram updates, clearing sweep and the response register.
`default_nettype none

module srow_back #(
   parameter int unsigned COUNTERS = 65536
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [srow_pkg::CSR_W-1:0]  counters_used,
   input  wire srow_pkg::item_type          head_item,
   input  wire logic                        queue_empty,
   output      logic                        pop,
   output      logic                        sweep_busy,
   srow_rsp_if.source                       rsp_if
);

   localparam int unsigned IDX_W   = (COUNTERS > 1) ? $clog2(COUNTERS) : 1;
   localparam int unsigned MOD_W   = $clog2(COUNTERS + 1);
   localparam int unsigned CMP_W   = (MOD_W > srow_pkg::CSR_W) ? MOD_W : srow_pkg::CSR_W;
   localparam int unsigned SWEEP   = (COUNTERS > srow_pkg::BINS) ? COUNTERS : srow_pkg::BINS;
   localparam int unsigned SWEEP_W = $clog2(SWEEP);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_CRD,
      ST_HOLD,
      ST_HNEW,
      ST_BIN,
      ST_RESP
   } state_type;

   state_type                          state_ff, state_in;
   logic [SWEEP_W-1:0]                 sweep_ff, sweep_in;
   logic                               clear_cmd_ff, clear_cmd_in;
   srow_pkg::op_type                   op_ff, op_in;
   logic [srow_pkg::VAL_W-1:0]         amt_ff, amt_in;
   logic [srow_pkg::VAL_W-1:0]         old_ff, old_in;
   logic [srow_pkg::VAL_W-1:0]         new_ff, new_in;
   logic [srow_pkg::VAL_W-1:0]         cval_ff, cval_in;
   logic [srow_pkg::BCNT_W-1:0]        bcount_ff, bcount_in;
   logic [srow_pkg::NZ_W-1:0]          nonzero_ff, nonzero_in;
   logic                               out_valid_ff, out_valid_in;
   logic [srow_pkg::VAL_W-1:0]         out_cval_ff, out_cval_in;
   logic [srow_pkg::BCNT_W-1:0]        out_bcount_ff, out_bcount_in;
   logic [srow_pkg::NZ_W-1:0]          out_nz_ff, out_nz_in;

   logic                               mod_start;
   logic                               mod_done;
   logic [MOD_W-1:0]                   mod_rem;
   logic [MOD_W-1:0]                   modulus;
   logic [CMP_W-1:0]                   used_ext;
   logic [IDX_W-1:0]                   pos;

   logic                               cnt_wr_en;
   logic [IDX_W-1:0]                   cnt_wr_addr;
   logic [srow_pkg::VAL_W-1:0]         cnt_wr_data;
   logic [srow_pkg::VAL_W-1:0]         cnt_rd_data;

   logic                               hist_wr_en;
   logic [srow_pkg::BIN_W-1:0]         hist_wr_addr;
   logic [srow_pkg::BCNT_W-1:0]        hist_wr_data;
   logic [srow_pkg::BIN_W-1:0]         hist_rd_addr;
   logic [srow_pkg::BCNT_W-1:0]        hist_rd_data;

   logic [srow_pkg::VAL_W:0]           sum;
   logic [srow_pkg::VAL_W-1:0]         upd_val;
   logic                               sweep_last;

   // Zero acts as one, anything above the row size acts as the row size
   always_comb begin
      used_ext = CMP_W'(counters_used);
      if (used_ext == '0) begin
         modulus = MOD_W'(1);
      end else if (used_ext > CMP_W'(COUNTERS)) begin
         modulus = MOD_W'(COUNTERS);
      end else begin
         modulus = used_ext[MOD_W-1:0];
      end
   end

   srow_mod #(.MOD_W(MOD_W)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (head_item.key_hash),
      .divisor   (modulus),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign pos = mod_rem[IDX_W-1:0];

   srow_ram #(.WIDTH(srow_pkg::VAL_W), .DEPTH(COUNTERS)) u_counter_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (pos),
      .rd_data (cnt_rd_data)
   );

   srow_ram #(.WIDTH(srow_pkg::BCNT_W), .DEPTH(srow_pkg::BINS)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   // Candidate new counter value from the fetched old value
   always_comb begin
      sum = {1'b0, cnt_rd_data} + {1'b0, amt_ff};
      unique case (op_ff)
         srow_pkg::OP_ADD: upd_val = sum[srow_pkg::VAL_W] ? srow_pkg::SAT_MAX
                                                          : sum[srow_pkg::VAL_W-1:0];
         srow_pkg::OP_MAX: upd_val = (amt_ff > cnt_rd_data) ? amt_ff : cnt_rd_data;
         default:          upd_val = cnt_rd_data;
      endcase
   end

   assign sweep_last = (sweep_ff == SWEEP_W'(SWEEP - 1));
   assign sweep_busy = (state_ff == ST_CLEAR);

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      clear_cmd_in  = clear_cmd_ff;
      op_in         = op_ff;
      amt_in        = amt_ff;
      old_in        = old_ff;
      new_in        = new_ff;
      cval_in       = cval_ff;
      bcount_in     = bcount_ff;
      nonzero_in    = nonzero_ff;
      out_valid_in  = out_valid_ff && !rsp_if.ready;
      out_cval_in   = out_cval_ff;
      out_bcount_in = out_bcount_ff;
      out_nz_in     = out_nz_ff;
      pop           = 1'b0;
      mod_start     = 1'b0;
      cnt_wr_en     = 1'b0;
      cnt_wr_addr   = pos;
      cnt_wr_data   = new_ff;
      hist_wr_en    = 1'b0;
      hist_wr_addr  = old_ff;
      hist_wr_data  = hist_rd_data;
      hist_rd_addr  = head_item.bin_index;

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_wr_en    = ({1'b0, sweep_ff} < (SWEEP_W+1)'(COUNTERS));
            cnt_wr_addr  = sweep_ff[IDX_W-1:0];
            cnt_wr_data  = '0;
            hist_wr_en   = ({1'b0, sweep_ff} < (SWEEP_W+1)'(srow_pkg::BINS));
            hist_wr_addr = sweep_ff[srow_pkg::BIN_W-1:0];
            hist_wr_data = '0;
            sweep_in     = sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = clear_cmd_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               pop       = 1'b1;
               op_in     = head_item.op;
               amt_in    = head_item.amount;
               cval_in   = '0;
               bcount_in = '0;
               unique case (head_item.op)
                  srow_pkg::OP_ADD, srow_pkg::OP_MAX, srow_pkg::OP_QUERY: begin
                     mod_start = 1'b1;
                     state_in  = ST_MOD;
                  end
                  srow_pkg::OP_CLEAR: begin
                     sweep_in     = '0;
                     clear_cmd_in = 1'b1;
                     nonzero_in   = '0;
                     state_in     = ST_CLEAR;
                  end
                  srow_pkg::OP_BIN: state_in = ST_BIN;
                  default:          state_in = ST_RESP;
               endcase
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = ST_CRD;
            end
         end
         ST_CRD: begin
            old_in       = cnt_rd_data;
            new_in       = upd_val;
            cval_in      = upd_val;
            hist_rd_addr = cnt_rd_data;
            if (upd_val != cnt_rd_data) begin
               // values only grow here, so a counter can only leave zero
               cnt_wr_en   = 1'b1;
               cnt_wr_data = upd_val;
               if (cnt_rd_data == '0) begin
                  nonzero_in = nonzero_ff + 1'b1;
               end
               state_in = ST_HOLD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_HOLD: begin
            hist_wr_en   = 1'b1;
            hist_wr_addr = old_ff;
            hist_wr_data = hist_rd_data - 1'b1;
            hist_rd_addr = new_ff;
            state_in     = ST_HNEW;
         end
         ST_HNEW: begin
            hist_wr_en   = 1'b1;
            hist_wr_addr = new_ff;
            hist_wr_data = hist_rd_data + 1'b1;
            state_in     = ST_RESP;
         end
         ST_BIN: begin
            bcount_in = hist_rd_data;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_if.ready) begin
               out_valid_in  = 1'b1;
               out_cval_in   = cval_ff;
               out_bcount_in = bcount_ff;
               out_nz_in     = nonzero_ff;
               clear_cmd_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      amt_ff        <= amt_in;
      old_ff        <= old_in;
      new_ff        <= new_in;
      cval_ff       <= cval_in;
      bcount_ff     <= bcount_in;
      out_cval_ff   <= out_cval_in;
      out_bcount_ff <= out_bcount_in;
      out_nz_ff     <= out_nz_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         clear_cmd_ff <= 1'b0;
         nonzero_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clear_cmd_ff <= clear_cmd_in;
         nonzero_ff   <= nonzero_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.counter_value = out_cval_ff;
   assign rsp_if.bin_count     = $signed(out_bcount_ff);
   assign rsp_if.nonzero_count = out_nz_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/saturating_counter_sketch_row.sv =====
// Top level of the sketch row counter block.
//
// One row of COUNTERS 8-bit saturating counters plus a 256-bin histogram of
// counter values. The front end decodes request transactions into a two-entry
// queue, so up to two transactions are taken while the back end is busy; the
// back end runs one transaction at a time. An add or raise that changes the
// counter passes the remainder unit, one counter read and two read-modify-write
// steps on the histogram RAM; a query or an unchanged counter skips the histogram
// steps. The remainder unit retires 4 quotient bits a cycle of the 32-bit hash.
// A bin read reads the histogram once, and an unknown command goes straight to the response.
// A clear sweeps max(COUNTERS, 256) entries, one a cycle, and the same sweep
// runs after reset; during it req_if.ready is low. Write csr only while idle.
`default_nettype none

module saturating_counter_sketch_row #(
   parameter int unsigned COUNTERS = 65536
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   srow_req_if.sink                         req_if,
   srow_rsp_if.source                       rsp_if,
   input  wire logic                        csr_write_enable,
   input  wire logic [srow_pkg::CSR_W-1:0]  csr_write_data
);

   logic [srow_pkg::CSR_W-1:0]  counters_used_ff, counters_used_in;
   logic                        push;
   srow_pkg::item_type          push_item;
   logic                        pop;
   srow_pkg::item_type          head_item;
   logic                        queue_empty;
   logic                        queue_full;
   logic                        sweep_busy;

   assign counters_used_in = csr_write_enable ? csr_write_data : counters_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         counters_used_ff <= srow_pkg::CSR_RESET;
      end else begin
         counters_used_ff <= counters_used_in;
      end
   end

   srow_front u_front (
      .req_if     (req_if),
      .queue_full (queue_full),
      .sweep_busy (sweep_busy),
      .push       (push),
      .push_item  (push_item)
   );

   srow_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   srow_back #(.COUNTERS(COUNTERS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .counters_used (counters_used_ff),
      .head_item     (head_item),
      .queue_empty   (queue_empty),
      .pop           (pop),
      .sweep_busy    (sweep_busy),
      .rsp_if        (rsp_if)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/srow_checker.sv =====
// Port-level checker for the sketch row counter block, with its bind.
`default_nettype none

module srow_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [srow_pkg::VAL_W-1:0]         rsp_counter_value,
   input wire logic signed [srow_pkg::BCNT_W-1:0] rsp_bin_count,
   input wire logic [srow_pkg::NZ_W-1:0]          rsp_nonzero_count
);

   // transactions accepted but not yet delivered
   logic [2:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + 1'b1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_counter_value)
         && $stable(rsp_bin_count) && $stable(rsp_nonzero_count))
      else $error("response changed while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response without an outstanding transaction");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd4)
      else $error("more transactions outstanding than the block can hold");

   a_sweep_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken before the clearing sweep");

   a_bin_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_counter_value != '0 |-> rsp_bin_count == '0)
      else $error("bin count reported alongside a counter value");

endmodule

bind saturating_counter_sketch_row srow_checker u_srow_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_counter_value (rsp_if.counter_value),
   .rsp_bin_count     (rsp_if.bin_count),
   .rsp_nonzero_count (rsp_if.nonzero_count)
);

`default_nettype wire

// ===== tb/tb_saturating_counter_sketch_row.sv =====
// Self-checking testbench for the sketch row of saturating counters with value histogram.
module tb_saturating_counter_sketch_row;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned COUNTERS       = 65536;
   // A clear sweep is the longest stretch with no transaction at all
   localparam int unsigned WATCHDOG_LIMIT = 4 * COUNTERS + 4096;
   localparam int unsigned SETTLE_CYCLES  = 16;
   localparam int unsigned MAX_PRINTED    = 40;

   localparam logic [srow_pkg::CMD_W-1:0]  CMD_TOP  = '1;
   localparam logic [srow_pkg::CSR_W-1:0]  CSR_TOP  = '1;
   localparam logic [srow_pkg::HASH_W-1:0] HASH_TOP = '1;
   localparam logic [srow_pkg::AMT_W-1:0]  AMT_TOP  = '1;

   typedef struct packed {
      logic [srow_pkg::VAL_W-1:0]         counter_value;
      logic signed [srow_pkg::BCNT_W-1:0] bin_count;
      logic [srow_pkg::NZ_W-1:0]          nonzero_count;
   } readout_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [srow_pkg::CSR_W-1:0] csr_write_data;

   srow_req_if req_if ();
   srow_rsp_if rsp_if ();

   saturating_counter_sketch_row #(.COUNTERS(COUNTERS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Predicted state of the row
   logic [srow_pkg::VAL_W-1:0]  row_counts [COUNTERS];
   logic [srow_pkg::BCNT_W-1:0] value_bins [srow_pkg::BINS];
   logic [srow_pkg::NZ_W-1:0]   nonzero_now;
   logic [srow_pkg::CSR_W-1:0]  counters_used_cfg;

   readout_type pending_readouts [$];
   int          mismatch_count;
   int          readouts_seen;
   int          stall_cycles;
   bit          idle_enable;
   int          long_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_row();
      foreach (row_counts[i]) row_counts[i] = '0;
      foreach (value_bins[i]) value_bins[i] = '0;
      nonzero_now = '0;
   endfunction

   // Move one counter to a new value and keep the histogram and nonzero tally in step
   function automatic void store_counter(int unsigned slot, logic [srow_pkg::VAL_W-1:0] nv);
      logic [srow_pkg::VAL_W-1:0] ov;
      ov = row_counts[slot];
      row_counts[slot] = nv;
      value_bins[ov] = value_bins[ov] - 1'b1;
      value_bins[nv] = value_bins[nv] + 1'b1;
      if (ov == '0 && nv != '0)
         nonzero_now = nonzero_now + 1'b1;
      else if (ov != '0 && nv == '0)
         nonzero_now = nonzero_now - 1'b1;
   endfunction

   function automatic readout_type apply_to_row(logic [srow_pkg::CMD_W-1:0] cmd,
                                                logic [srow_pkg::HASH_W-1:0] hash,
                                                logic [srow_pkg::AMT_W-1:0] amt,
                                                logic [srow_pkg::BIN_W-1:0] bin);
      readout_type                r;
      logic [srow_pkg::VAL_W-1:0] lim;
      int unsigned                modulus;
      int unsigned                slot;
      int unsigned                sum;
      r = '0;
      lim = (amt > srow_pkg::SAT_MAX) ? srow_pkg::SAT_MAX : amt[srow_pkg::VAL_W-1:0];
      modulus = counters_used_cfg;
      if (modulus == 0) modulus = 1;
      if (modulus > COUNTERS) modulus = COUNTERS;
      slot = hash % modulus;
      case (cmd)
         srow_pkg::CMD_ADD: begin
            sum = row_counts[slot] + lim;
            if (sum > srow_pkg::SAT_MAX) sum = srow_pkg::SAT_MAX;
            store_counter(slot, srow_pkg::VAL_W'(sum));
            r.counter_value = row_counts[slot];
         end
         srow_pkg::CMD_MAX: begin
            if (row_counts[slot] < lim) store_counter(slot, lim);
            r.counter_value = row_counts[slot];
         end
         srow_pkg::CMD_QUERY: r.counter_value = row_counts[slot];
         srow_pkg::CMD_CLEAR: clear_row();
         srow_pkg::CMD_BIN:   r.bin_count = value_bins[bin];
         default: ;
      endcase
      r.nonzero_count = nonzero_now;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t ns: %s", $time, msg);
   endtask

   // Predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      readout_type want;
      bit          moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            readouts_seen++;
            if (pending_readouts.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                         readouts_seen));
            end else begin
               want = pending_readouts.pop_front();
               if (rsp_if.counter_value !== want.counter_value)
                  report_mismatch($sformatf("response %0d counter_value got %0d want %0d",
                                            readouts_seen, rsp_if.counter_value,
                                            want.counter_value));
               if (rsp_if.bin_count !== want.bin_count)
                  report_mismatch($sformatf("response %0d bin_count got %0d want %0d",
                                            readouts_seen, rsp_if.bin_count,
                                            want.bin_count));
               if (rsp_if.nonzero_count !== want.nonzero_count)
                  report_mismatch($sformatf("response %0d nonzero_count got %0d want %0d",
                                            readouts_seen, rsp_if.nonzero_count,
                                            want.nonzero_count));
            end
         end
         if (req_if.valid && req_if.ready) begin
            moved = 1'b1;
            pending_readouts.push_back(apply_to_row(req_if.cmd, req_if.key_hash,
                                                    req_if.amount, req_if.bin_index));
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
      end
   end

   // Response side: random stall bursts, plus a long hold when a test asks for one
   initial begin
      int hold;
      rsp_if.ready = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (long_hold_cycles > 0) begin
            hold = long_hold_cycles;
            long_hold_cycles = 0;
         end
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            hold--;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 6) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      wait (reset == 1'b0);
      while (stall_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_item(logic [srow_pkg::CMD_W-1:0] cmd, logic [srow_pkg::HASH_W-1:0] hash,
                            logic [srow_pkg::AMT_W-1:0] amt, logic [srow_pkg::BIN_W-1:0] bin);
      int gap;
      gap = (idle_enable && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.cmd       <= cmd;
      req_if.key_hash  <= hash;
      req_if.amount    <= amt;
      req_if.bin_index <= bin;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_random_item();
      int                          pick;
      logic [srow_pkg::CMD_W-1:0]  cmd;
      logic [srow_pkg::HASH_W-1:0] hash;
      logic [srow_pkg::AMT_W-1:0]  amt;
      logic [srow_pkg::BIN_W-1:0]  bin;
      pick = $urandom_range(0, 99);
      // Clears sweep the whole row, so keep them rare
      if ($urandom_range(0, 399) == 0) cmd = srow_pkg::CMD_CLEAR;
      else if (pick < 35) cmd = srow_pkg::CMD_ADD;
      else if (pick < 55) cmd = srow_pkg::CMD_MAX;
      else if (pick < 75) cmd = srow_pkg::CMD_QUERY;
      else if (pick < 94) cmd = srow_pkg::CMD_BIN;
      else cmd = srow_pkg::CMD_W'($urandom_range(srow_pkg::CMD_BIN + 1, CMD_TOP));
      // Low hashes make counters collide even with a wide modulus
      hash = $urandom_range(0, 1) ? srow_pkg::HASH_W'($urandom)
                                  : srow_pkg::HASH_W'($urandom_range(0, 63));
      case ($urandom_range(0, 4))
         0, 1, 2: amt = srow_pkg::AMT_W'($urandom_range(0, 40));
         3:       amt = srow_pkg::AMT_W'($urandom_range(0, 300));
         default: amt = srow_pkg::AMT_W'($urandom);
      endcase
      bin = $urandom_range(0, 1) ? srow_pkg::BIN_W'($urandom_range(0, 8))
                                 : srow_pkg::BIN_W'($urandom);
      send_item(cmd, hash, amt, bin);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_readouts.size() != 0) @(negedge clock);
   endtask

   task automatic program_counters_used(logic [srow_pkg::CSR_W-1:0] value);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      counters_used_cfg = value;
   endtask

   task automatic test_directed_ops();
      int c;
      send_item(srow_pkg::CMD_QUERY, '0, '0, '0);
      send_item(srow_pkg::CMD_BIN, '0, '0, '0);
      // Adding zero leaves the counter at zero and its bin count unchanged
      send_item(srow_pkg::CMD_ADD, HASH_TOP, '0, '0);
      send_item(srow_pkg::CMD_ADD, HASH_TOP, AMT_TOP, '0);
      send_item(srow_pkg::CMD_ADD, HASH_TOP, srow_pkg::AMT_W'(1), '0);
      send_item(srow_pkg::CMD_MAX, srow_pkg::HASH_W'(5), srow_pkg::AMT_W'(200), '0);
      send_item(srow_pkg::CMD_MAX, srow_pkg::HASH_W'(5), srow_pkg::AMT_W'(100), '0);
      send_item(srow_pkg::CMD_MAX, srow_pkg::HASH_W'(5), srow_pkg::AMT_W'(256), '0);
      send_item(srow_pkg::CMD_BIN, '0, '0, srow_pkg::BIN_W'(255));
      send_item(srow_pkg::CMD_BIN, '0, '0, '0);
      send_item(srow_pkg::CMD_BIN, HASH_TOP, AMT_TOP, srow_pkg::BIN_W'(200));
      for (c = srow_pkg::CMD_BIN + 1; c <= CMD_TOP; c++)
         send_item(srow_pkg::CMD_W'(c), HASH_TOP, AMT_TOP, '1);
      send_item(srow_pkg::CMD_QUERY, srow_pkg::HASH_W'(5), '0, '0);
      send_item(srow_pkg::CMD_CLEAR, HASH_TOP, AMT_TOP, '1);
      send_item(srow_pkg::CMD_BIN, '0, '0, '0);
      send_item(srow_pkg::CMD_QUERY, HASH_TOP, '0, '0);
   endtask

   task automatic test_modulus_extremes();
      // Zero behaves as a single counter
      program_counters_used('0);
      send_item(srow_pkg::CMD_ADD, HASH_TOP, srow_pkg::AMT_W'(7), '0);
      send_item(srow_pkg::CMD_QUERY, srow_pkg::HASH_W'(32'h1234_5678), '0, '0);
      // Above the row size clips to the row size; earlier counts survive the change
      program_counters_used(CSR_TOP);
      send_item(srow_pkg::CMD_ADD, HASH_TOP, srow_pkg::AMT_W'(3), '0);
      send_item(srow_pkg::CMD_QUERY, srow_pkg::HASH_W'(32'h0001_FFFF), '0, '0);
      send_item(srow_pkg::CMD_QUERY, '0, '0, '0);
      program_counters_used(srow_pkg::CSR_RESET);
   endtask

   task automatic test_output_backpressure();
      // Hold responses while requests keep coming, so the input stalls
      long_hold_cycles = 400;
      repeat (24) send_random_item();
   endtask

   task automatic test_drain_pause();
      repeat (12) send_random_item();
      wait_results_drained();
      repeat (12) send_random_item();
   endtask

   task automatic test_random_phases();
      logic [srow_pkg::CSR_W-1:0] cfg_list [8];
      int                         count_list [8];
      int                         p;
      cfg_list   = '{srow_pkg::CSR_RESET, 3, 200, 1, srow_pkg::CSR_RESET - 1, CSR_TOP, 0, 0};
      count_list = '{450, 250, 350, 100, 200, 200, 50, 200};
      cfg_list[7] = srow_pkg::CSR_W'($urandom_range(1, CSR_TOP));
      for (p = 0; p < 8; p++) begin
         // Run the last phase flat out
         if (p == 7) idle_enable = 1'b0;
         program_counters_used(cfg_list[p]);
         repeat (count_list[p]) send_random_item();
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.cmd       = '0;
      req_if.key_hash  = '0;
      req_if.amount    = '0;
      req_if.bin_index = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      idle_enable      = 1'b1;
      long_hold_cycles = 0;
      mismatch_count   = 0;
      readouts_seen    = 0;
      stall_cycles     = 0;
      counters_used_cfg = srow_pkg::CSR_RESET;
      clear_row();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_modulus_extremes();
      test_output_backpressure();
      test_drain_pause();
      test_random_phases();

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_readouts.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/srow_pkg.sv
hw/rtl/srow_if.sv
hw/rtl/srow_ram.sv
hw/rtl/srow_front.sv
hw/rtl/srow_fifo.sv
hw/rtl/srow_mod.sv
hw/rtl/srow_back.sv
hw/rtl/saturating_counter_sketch_row.sv
hw/rtl/srow_checker.sv
tb/tb_saturating_counter_sketch_row.sv
